// ===== sv/ise_pkg.sv =====
// ============================================================================
// ise_pkg
// Shared types and constants of the inertia scroll engine: datapath widths,
// configuration register indexes, item opcodes, sequencer states and divider status.
// ============================================================================
package ise_pkg;

    // Field widths.
    localparam int DIST_W = 24;
    localparam int VEL_W  = 16;
    localparam int TIME_W = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DISTANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NATURAL_SCROLL = 3'd4;

    // Item opcodes.
    localparam logic OP_TOUCH = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Shared multiplier operand and product widths.
    localparam int MA_W = 27;
    localparam int MB_W = 25;
    localparam int MP_W = MA_W + MB_W;

    // Shared divider: dividend, divisor and quotient widths.
    localparam int DVD_W  = 59;
    localparam int DVS_W  = 51;
    localparam int QUO_W  = 25;
    localparam int QCNT_W = $clog2(QUO_W + 1);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_X_GO,
        ST_DIV_X_WAIT,
        ST_DIV_Y_GO,
        ST_DIV_Y_WAIT,
        ST_DUR_MUL,
        ST_DUR_LOAD,
        ST_DUR_GO,
        ST_DUR_WAIT,
        ST_TICK_MUL1,
        ST_TICK_MUL2,
        ST_TICK_MUL3,
        ST_TICK_LOAD,
        ST_DONE
    } state_t;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic done;
        logic ovf;
    } div_status_t;

endpackage

// ===== sv/ise_mul.sv =====
// ============================================================================
// ise_mul
// Shared unsigned multiplier with a registered product. The sequencer loads
// new operands and sets the enable; the product is ready in the next cycle.
// ============================================================================
module ise_mul (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [ise_pkg::MA_W-1:0]  a,
    input  logic [ise_pkg::MB_W-1:0]  b,
    output logic [ise_pkg::MP_W-1:0]  p
);

    logic [ise_pkg::MP_W-1:0] p_reg;
    logic [ise_pkg::MP_W-1:0] p_next;

    // Both operands are zero extended to the product width.
    assign p_next = {{ise_pkg::MB_W{1'b0}}, a} * {{ise_pkg::MA_W{1'b0}}, b};

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== sv/ise_div.sv =====
// ============================================================================
// ise_div
// Shared restoring divider, one quotient bit per cycle. A quotient that
// would not fit in QUO_W bits is flagged as overflow right after start.
// ============================================================================
module ise_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ise_pkg::DVD_W-1:0]  dividend,
    input  logic [ise_pkg::DVS_W-1:0]  divisor,
    output logic [ise_pkg::QUO_W-1:0]  quotient,
    output ise_pkg::div_status_t       status
);

    localparam int HI_W  = ise_pkg::DVD_W - ise_pkg::QUO_W;
    localparam int PAD_W = ise_pkg::DVS_W - HI_W;

    logic [ise_pkg::DVS_W-1:0]  rem_reg, rem_next;
    logic [ise_pkg::QUO_W-1:0]  qr_reg, qr_next;
    logic [ise_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic                       ovf_reg, ovf_next;

    logic [ise_pkg::DVS_W-1:0]  hi_part;
    logic [ise_pkg::DVS_W:0]    shifted;
    logic [ise_pkg::DVS_W:0]    trial;
    logic                       qbit;

    // Upper dividend bits must stay below the divisor for the quotient to fit.
    assign hi_part = {{PAD_W{1'b0}}, dividend[ise_pkg::DVD_W-1:ise_pkg::QUO_W]};

    // Bring down the next dividend bit and try to subtract the divisor.
    assign shifted = {rem_reg, qr_reg[ise_pkg::QUO_W-1]};
    assign trial   = shifted - {1'b0, divisor};
    assign qbit    = (shifted >= {1'b0, divisor});

    always_comb begin
        rem_next  = rem_reg;
        qr_next   = qr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        if (start) begin
            if (hi_part >= divisor) begin
                ovf_next  = 1'b1;
                done_next = 1'b1;
            end else begin
                ovf_next  = 1'b0;
                rem_next  = hi_part;
                qr_next   = dividend[ise_pkg::QUO_W-1:0];
                cnt_next  = ise_pkg::QCNT_W'(ise_pkg::QUO_W);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = qbit ? trial[ise_pkg::DVS_W-1:0] : shifted[ise_pkg::DVS_W-1:0];
            qr_next  = {qr_reg[ise_pkg::QUO_W-2:0], qbit};
            cnt_next = cnt_reg - ise_pkg::QCNT_W'(1);
            if (cnt_reg == ise_pkg::QCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        qr_reg  <= qr_next;
        ovf_reg <= ovf_next;
    end

    assign quotient    = qr_reg;
    assign status.done = done_reg;
    assign status.ovf  = ovf_reg;

endmodule

// ===== sv/inertia_scroll_engine_core.sv =====
// ============================================================================
// inertia_scroll_engine_core
// Kinetic scroller with linear deceleration: passes held scroll distances
// through and slides vertically after release until the slide time runs out.
// ============================================================================
// The block takes one transaction at a time and is not ready while it works
// on it. The shared divider produces one quotient bit per cycle: a held touch
// report needs two divisions, a release that starts a slide needs one, a
// slide tick needs three multiplications and one division, and every other
// item needs no division. The result sits in an output register, so the
// next item is accepted while a finished result still waits to be taken.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata; the
// user must write it only while the block is idle, and the block has no guard
// for this. An index beyond the register list is ignored.
module inertia_scroll_engine_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_wr_en,
    input  logic [ise_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ise_pkg::CFG_DATA_W-1:0]        cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_op,
    input  logic                                  s_holding,
    input  logic signed [ise_pkg::DIST_W-1:0]     s_scroll_dx,
    input  logic signed [ise_pkg::DIST_W-1:0]     s_scroll_dy,
    input  logic signed [ise_pkg::VEL_W-1:0]      s_velocity_x,
    input  logic signed [ise_pkg::VEL_W-1:0]      s_velocity_y,
    input  logic                                  s_pointer_moved,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_scroll_valid,
    output logic signed [ise_pkg::DIST_W-1:0]     m_scroll_out_x,
    output logic signed [ise_pkg::DIST_W-1:0]     m_scroll_out_y,
    output logic                                  m_inertia_active,
    output logic                                  m_inertia_changed
);

    localparam logic [ise_pkg::DIST_W-1:0] SAT_POS  = 24'h7FFFFF;
    localparam logic [ise_pkg::DIST_W-1:0] SAT_NEG  = 24'h800000;
    localparam logic [ise_pkg::TIME_W-1:0] TIME_MAX = 24'hFFFFFF;
    localparam logic [ise_pkg::MA_W-1:0]   DUR_SCALE = 27'd1000;

    // ------------------------------------------------------------------
    // Helper functions.
    // ------------------------------------------------------------------
    function automatic logic [ise_pkg::VEL_W-1:0] mag16(input logic [ise_pkg::VEL_W-1:0] v);
        return v[ise_pkg::VEL_W-1] ? (~v + 16'd1) : v;
    endfunction

    function automatic logic [ise_pkg::DIST_W-1:0] mag24(
        input logic [ise_pkg::DIST_W-1:0] v
    );
        return v[ise_pkg::DIST_W-1] ? (~v + 24'd1) : v;
    endfunction

    // Apply the sign and saturate to the 24-bit signed range.
    function automatic logic [ise_pkg::DIST_W-1:0] sat_emit(
        input logic                       neg,
        input logic [ise_pkg::QUO_W-1:0]  q,
        input logic                       ovf
    );
        logic [ise_pkg::DIST_W-1:0] r;
        if (neg) begin
            if (ovf || (q > {1'b0, SAT_NEG})) begin
                r = SAT_NEG;
            end else begin
                r = ~q[ise_pkg::DIST_W-1:0] + 24'd1;
            end
        end else begin
            if (ovf || (q > {1'b0, SAT_POS})) begin
                r = SAT_POS;
            end else begin
                r = q[ise_pkg::DIST_W-1:0];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Declarations.
    // ------------------------------------------------------------------
    ise_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic [14:0] trig_reg;
    logic [15:0] fric_reg;
    logic [9:0]  tick_reg;
    logic [15:0] step_reg;
    logic        nat_reg;

    // Latched input transaction.
    logic                             op_reg;
    logic                             hold_reg;
    logic [ise_pkg::DIST_W-1:0]       dx_reg;
    logic [ise_pkg::DIST_W-1:0]       dy_reg;
    logic [ise_pkg::VEL_W-1:0]        in_vx_reg;
    logic [ise_pkg::VEL_W-1:0]        in_vy_reg;
    logic                             pm_reg;

    // Scroller state.
    logic                             sliding_reg;
    logic [ise_pkg::VEL_W-1:0]        hvx_reg;
    logic [ise_pkg::VEL_W-1:0]        hvy_reg;
    logic [ise_pkg::VEL_W-1:0]        sv_reg;
    logic [ise_pkg::TIME_W-1:0]       dur_reg;
    logic [ise_pkg::TIME_W-1:0]       el_reg;

    // Working registers of the current item.
    logic                             was_reg;
    logic                             negx_reg;
    logic                             negy_reg;
    logic [9:0]                       d1_reg;
    logic [ise_pkg::TIME_W:0]         s2_reg;
    logic [ise_pkg::DVD_W-2:0]        num_reg;
    logic [ise_pkg::DVD_W-1:0]        dvd_reg;
    logic [ise_pkg::DVS_W-1:0]        dvs_reg;
    logic                             res_valid_reg;
    logic [ise_pkg::DIST_W-1:0]       res_x_reg;
    logic [ise_pkg::DIST_W-1:0]       res_y_reg;

    // Output register.
    logic                             m_valid_reg;
    logic                             m_scroll_valid_reg;
    logic [ise_pkg::DIST_W-1:0]       m_x_reg;
    logic [ise_pkg::DIST_W-1:0]       m_y_reg;
    logic                             m_active_reg;
    logic                             m_changed_reg;

    // Shared units.
    logic                             mul_en;
    logic [ise_pkg::MA_W-1:0]         mul_a;
    logic [ise_pkg::MB_W-1:0]         mul_b;
    logic [ise_pkg::MP_W-1:0]         mul_p;
    logic                             div_start;
    logic [ise_pkg::QUO_W-1:0]        div_q;
    ise_pkg::div_status_t             div_st;

    // Decode helpers.
    logic [15:0]                      step_eff;
    logic [15:0]                      fric_eff;
    logic [ise_pkg::MA_W-1:0]         step_x2000;
    logic                             trig_hit;
    logic                             out_free;
    logic [ise_pkg::TIME_W:0]         e_plus_i;
    logic [ise_pkg::TIME_W-1:0]       t2;
    logic [ise_pkg::TIME_W-1:0]       d1_full;
    logic [ise_pkg::TIME_W:0]         s2;
    logic [ise_pkg::TIME_W-1:0]       el_sat;
    logic                             tick_emit;
    logic                             tick_end;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_reg <= 15'd100;
            fric_reg <= 16'd1000;
            tick_reg <= 10'd16;
            step_reg <= 16'd1;
            nat_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ise_pkg::CFG_TRIGGER_SPEED:  trig_reg <= cfg_wdata[14:0];
                ise_pkg::CFG_FRICTION:       fric_reg <= cfg_wdata;
                ise_pkg::CFG_TICK_INTERVAL:  tick_reg <= cfg_wdata[9:0];
                ise_pkg::CFG_STEP_DISTANCE:  step_reg <= cfg_wdata;
                ise_pkg::CFG_NATURAL_SCROLL: nat_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Decode helpers. A zero step distance or friction acts as one.
    // ------------------------------------------------------------------
    assign step_eff = (step_reg == 16'd0) ? 16'd1 : step_reg;
    assign fric_eff = (fric_reg == 16'd0) ? 16'd1 : fric_reg;

    // step * 2000 as 2048 - 32 - 16.
    assign step_x2000 = ({11'd0, step_eff} << 11) - ({11'd0, step_eff} << 5)
                      - ({11'd0, step_eff} << 4);

    assign trig_hit = (mag16(hvx_reg) > {1'b0, trig_reg})
                   || (mag16(hvy_reg) > {1'b0, trig_reg});

    assign out_free = !m_valid_reg || m_ready;

    // Tick: slide one interval further, or close out at the slide duration.
    always_comb begin
        e_plus_i  = {1'b0, el_reg} + {15'd0, tick_reg};
        tick_emit = 1'b0;
        tick_end  = 1'b0;
        t2        = dur_reg;
        if (e_plus_i < {1'b0, dur_reg}) begin
            tick_emit = 1'b1;
            t2        = e_plus_i[ise_pkg::TIME_W-1:0];
        end else if (el_reg < dur_reg) begin
            tick_emit = 1'b1;
            tick_end  = 1'b1;
        end else begin
            tick_end  = 1'b1;
        end
        d1_full = t2 - el_reg;
        s2      = {dur_reg, 1'b0} - {1'b0, el_reg} - {1'b0, t2};
        el_sat  = e_plus_i[ise_pkg::TIME_W] ? TIME_MAX : e_plus_i[ise_pkg::TIME_W-1:0];
    end

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ise_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = ise_pkg::ST_DECODE;
                end
            end
            ise_pkg::ST_DECODE: begin
                if (op_reg == ise_pkg::OP_TOUCH) begin
                    if (hold_reg) begin
                        state_next = ise_pkg::ST_DIV_X_GO;
                    end else if (trig_hit) begin
                        state_next = ise_pkg::ST_DUR_MUL;
                    end else begin
                        state_next = ise_pkg::ST_DONE;
                    end
                end else if (sliding_reg && tick_emit) begin
                    state_next = ise_pkg::ST_TICK_MUL1;
                end else begin
                    state_next = ise_pkg::ST_DONE;
                end
            end
            ise_pkg::ST_DIV_X_GO:   state_next = ise_pkg::ST_DIV_X_WAIT;
            ise_pkg::ST_DIV_X_WAIT: begin
                if (div_st.done) begin
                    state_next = ise_pkg::ST_DIV_Y_GO;
                end
            end
            ise_pkg::ST_DIV_Y_GO:   state_next = ise_pkg::ST_DIV_Y_WAIT;
            ise_pkg::ST_DIV_Y_WAIT: begin
                if (div_st.done) begin
                    state_next = ise_pkg::ST_DONE;
                end
            end
            ise_pkg::ST_DUR_MUL:    state_next = ise_pkg::ST_DUR_LOAD;
            ise_pkg::ST_DUR_LOAD:   state_next = ise_pkg::ST_DUR_GO;
            ise_pkg::ST_DUR_GO:     state_next = ise_pkg::ST_DUR_WAIT;
            ise_pkg::ST_DUR_WAIT: begin
                if (div_st.done) begin
                    state_next = ise_pkg::ST_DONE;
                end
            end
            ise_pkg::ST_TICK_MUL1:  state_next = ise_pkg::ST_TICK_MUL2;
            ise_pkg::ST_TICK_MUL2:  state_next = ise_pkg::ST_TICK_MUL3;
            ise_pkg::ST_TICK_MUL3:  state_next = ise_pkg::ST_TICK_LOAD;
            ise_pkg::ST_TICK_LOAD:  state_next = ise_pkg::ST_DIV_Y_GO;
            ise_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = ise_pkg::ST_IDLE;
                end
            end
            default: state_next = ise_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ise_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: controls for the shared units.
    // ------------------------------------------------------------------
    always_comb begin
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        case (state_reg)
            ise_pkg::ST_DUR_MUL: begin
                // 1000 * |v|
                mul_en = 1'b1;
                mul_a  = DUR_SCALE;
                mul_b  = {9'd0, mag16(sv_reg)};
            end
            ise_pkg::ST_TICK_MUL1: begin
                // |v| * (t2 - t1)
                mul_en = 1'b1;
                mul_a  = {11'd0, mag16(sv_reg)};
                mul_b  = {15'd0, d1_reg};
            end
            ise_pkg::ST_TICK_MUL2: begin
                // ... * (2T - t1 - t2)
                mul_en = 1'b1;
                mul_a  = mul_p[ise_pkg::MA_W-1:0];
                mul_b  = s2_reg;
            end
            ise_pkg::ST_TICK_MUL3: begin
                // Denominator 2000 * step * T.
                mul_en = 1'b1;
                mul_a  = step_x2000;
                mul_b  = {1'b0, dur_reg};
            end
            ise_pkg::ST_DIV_X_GO,
            ise_pkg::ST_DIV_Y_GO,
            ise_pkg::ST_DUR_GO: begin
                div_start = 1'b1;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Scroller state and output valid.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sliding_reg <= 1'b0;
            hvx_reg     <= '0;
            hvy_reg     <= '0;
            sv_reg      <= '0;
            dur_reg     <= '0;
            el_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ise_pkg::ST_DECODE: begin
                    if (op_reg == ise_pkg::OP_TOUCH) begin
                        if (hold_reg) begin
                            sliding_reg <= 1'b0;
                            hvx_reg     <= in_vx_reg;
                            hvy_reg     <= in_vy_reg;
                        end else begin
                            if (trig_hit) begin
                                // Release with enough speed (re)starts the slide.
                                sliding_reg <= 1'b1;
                                el_reg      <= '0;
                                sv_reg      <= hvy_reg;
                            end else if (pm_reg) begin
                                sliding_reg <= 1'b0;
                            end
                            hvx_reg <= '0;
                            hvy_reg <= '0;
                        end
                    end else if (sliding_reg) begin
                        el_reg <= el_sat;
                        if (tick_end) begin
                            sliding_reg <= 1'b0;
                        end
                    end
                end
                ise_pkg::ST_DUR_WAIT: begin
                    if (div_st.done) begin
                        dur_reg <= (div_st.ovf || div_q[ise_pkg::QUO_W-1]) ?
                                   TIME_MAX : div_q[ise_pkg::TIME_W-1:0];
                    end
                end
                default: ;
            endcase

            // Output handshake.
            if ((state_reg == ise_pkg::ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input latch, working registers and output payload.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ise_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_reg    <= s_op;
                    hold_reg  <= s_holding;
                    dx_reg    <= s_scroll_dx;
                    dy_reg    <= s_scroll_dy;
                    in_vx_reg <= s_velocity_x;
                    in_vy_reg <= s_velocity_y;
                    pm_reg    <= s_pointer_moved;
                end
            end
            ise_pkg::ST_DECODE: begin
                was_reg       <= sliding_reg;
                res_valid_reg <= 1'b0;
                res_x_reg     <= '0;
                res_y_reg     <= '0;
                negx_reg      <= dx_reg[ise_pkg::DIST_W-1] ^ nat_reg;
                negy_reg      <= dy_reg[ise_pkg::DIST_W-1] ^ nat_reg;
                dvs_reg       <= {35'd0, step_eff};
                dvd_reg       <= {35'd0, mag24(dx_reg)} + {44'd0, step_eff[15:1]};
                d1_reg        <= d1_full[9:0];
                s2_reg        <= s2;
                if (op_reg == ise_pkg::OP_TOUCH) begin
                    res_valid_reg <= hold_reg;
                end else begin
                    res_valid_reg <= sliding_reg && tick_emit;
                    negy_reg      <= sv_reg[ise_pkg::VEL_W-1] ^ nat_reg;
                end
            end
            ise_pkg::ST_DIV_X_WAIT: begin
                if (div_st.done) begin
                    res_x_reg <= sat_emit(negx_reg, div_q, div_st.ovf);
                    dvd_reg   <= {35'd0, mag24(dy_reg)} + {44'd0, step_eff[15:1]};
                end
            end
            ise_pkg::ST_DIV_Y_WAIT: begin
                if (div_st.done) begin
                    res_y_reg <= sat_emit(negy_reg, div_q, div_st.ovf);
                end
            end
            ise_pkg::ST_DUR_LOAD: begin
                dvd_reg <= {7'd0, mul_p};
                dvs_reg <= {35'd0, fric_eff};
            end
            ise_pkg::ST_TICK_MUL3: begin
                num_reg <= {mul_p[49:0], 8'd0};
            end
            ise_pkg::ST_TICK_LOAD: begin
                // Round half away from zero: add half the denominator.
                dvs_reg <= mul_p[ise_pkg::DVS_W-1:0];
                dvd_reg <= {1'b0, num_reg} + {9'd0, mul_p[ise_pkg::DVS_W-1:1]};
            end
            ise_pkg::ST_DONE: begin
                if (out_free) begin
                    m_scroll_valid_reg <= res_valid_reg;
                    m_x_reg            <= res_x_reg;
                    m_y_reg            <= res_y_reg;
                    m_active_reg       <= sliding_reg;
                    m_changed_reg      <= sliding_reg ^ was_reg;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared arithmetic units.
    // ------------------------------------------------------------------
    ise_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    ise_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .quotient (div_q),
        .status   (div_st)
    );

    // ------------------------------------------------------------------
    // Ports.
    // ------------------------------------------------------------------
    assign s_ready           = (state_reg == ise_pkg::ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_scroll_valid    = m_scroll_valid_reg;
    assign m_scroll_out_x    = m_x_reg;
    assign m_scroll_out_y    = m_y_reg;
    assign m_inertia_active  = m_active_reg;
    assign m_inertia_changed = m_changed_reg;

endmodule

// ===== sv/ise_checker.sv =====
// ============================================================================
// ise_checker
// Port-level checks of the inertia scroll engine, bound to the top level.
// ============================================================================
module ise_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [ise_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ise_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic                                  s_op,
    input  logic                                  s_holding,
    input  logic signed [ise_pkg::DIST_W-1:0]     s_scroll_dx,
    input  logic signed [ise_pkg::DIST_W-1:0]     s_scroll_dy,
    input  logic signed [ise_pkg::VEL_W-1:0]      s_velocity_x,
    input  logic signed [ise_pkg::VEL_W-1:0]      s_velocity_y,
    input  logic                                  s_pointer_moved,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic                                  m_scroll_valid,
    input  logic signed [ise_pkg::DIST_W-1:0]     m_scroll_out_x,
    input  logic signed [ise_pkg::DIST_W-1:0]     m_scroll_out_y,
    input  logic                                  m_inertia_active,
    input  logic                                  m_inertia_changed
);

    // Sliding state reported by the last delivered transaction.
    logic prev_active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_active_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            prev_active_reg <= m_inertia_active;
        end
    end

    // Nothing is pending right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // One transaction at a time: input is closed the cycle after acceptance.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted transaction");

    // A result without scroll event carries zero distances.
    a_quiet_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_scroll_valid |-> (m_scroll_out_x == '0) && (m_scroll_out_y == '0))
        else $error("scroll distance on a result without scroll event");

    // The change flag follows the sliding state of consecutive results.
    a_change_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_inertia_changed == (m_inertia_active != prev_active_reg))
        else $error("inertia change flag disagrees with previous result");

    // A stalled result stays valid and keeps its y distance and sliding state.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scroll_out_y)
                                && $stable(m_inertia_active))
        else $error("stalled result changed");

endmodule

bind inertia_scroll_engine_core ise_checker u_ise_checker (.*);

// ===== test/tb.sv =====
// ============================================================================
// tb
// Self-checking bench for the inertia scroll engine core. Touch reports and
// slide ticks go in over a valid/ready channel. A built-in predictor tracks
// the scroller state and configuration and works out the result of every
// accepted transaction. Each returned transaction is checked field by field.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ise_pkg::*;

    localparam int                   CYCLE_LIMIT    = 1000000;
    localparam int                   RANDOM_ITEMS   = 1700;
    localparam int                   DRAIN_CYCLES   = 80;
    localparam logic [63:0]          SAT24          = 64'hFF_FFFF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic        op;
        logic        holding;
        logic [23:0] dx;
        logic [23:0] dy;
        logic [15:0] vx;
        logic [15:0] vy;
        logic        moved;
    } touch_item_t;

    typedef struct packed {
        logic        scroll_valid;
        logic [23:0] out_x;
        logic [23:0] out_y;
        logic        active;
        logic        changed;
    } scroll_result_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_op;
    logic                    s_holding;
    logic [DIST_W-1:0]       s_scroll_dx;
    logic [DIST_W-1:0]       s_scroll_dy;
    logic [VEL_W-1:0]        s_velocity_x;
    logic [VEL_W-1:0]        s_velocity_y;
    logic                    s_pointer_moved;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_scroll_valid;
    logic [DIST_W-1:0]       m_scroll_out_x;
    logic [DIST_W-1:0]       m_scroll_out_y;
    logic                    m_inertia_active;
    logic                    m_inertia_changed;

    // Predicted scroller state and configuration.
    logic                    slide_on;
    logic [15:0]             held_vx;
    logic [15:0]             held_vy;
    logic [15:0]             slide_vel;
    logic [23:0]             slide_len_ms;
    logic [23:0]             slide_elapsed_ms;
    logic [14:0]             reg_trigger;
    logic [15:0]             reg_friction;
    logic [9:0]              reg_tick_ms;
    logic [15:0]             reg_step;
    logic                    reg_natural;

    scroll_result_t          expected_scrolls[$];
    scroll_result_t          head_res;
    int                      mismatch_count;
    int                      cycle_count;
    int                      items_sent;
    int                      src_max_gap;
    int                      sink_max_gap;
    int                      sink_hold_req;

    inertia_scroll_engine_core u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_holding         (s_holding),
        .s_scroll_dx       (s_scroll_dx),
        .s_scroll_dy       (s_scroll_dy),
        .s_velocity_x      (s_velocity_x),
        .s_velocity_y      (s_velocity_y),
        .s_pointer_moved   (s_pointer_moved),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_scroll_valid    (m_scroll_valid),
        .m_scroll_out_x    (m_scroll_out_x),
        .m_scroll_out_y    (m_scroll_out_y),
        .m_inertia_active  (m_inertia_active),
        .m_inertia_changed (m_inertia_changed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Magnitude of a two's complement 24-bit value, widened to 64 bits.
    function automatic logic [63:0] mag24(input logic [23:0] v);
        logic [23:0] m;
        m = v[23] ? (~v + 24'd1) : v;
        return {40'd0, m};
    endfunction

    // Divides a magnitude with rounding half away from zero, applies the sign
    // and saturates to the 24-bit output range.
    function automatic logic [23:0] round_sat(input logic neg, input logic [63:0] mag,
                                              input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = (mag + den / 2) / den;
        if (neg) begin
            if (q > 64'd8388608) q = 64'd8388608;
            r = 64'd0 - q;
        end else begin
            if (q > 64'd8388607) q = 64'd8388607;
            r = q;
        end
        return r[23:0];
    endfunction

    // Advances the predicted scroller by one transaction and returns the
    // result that the block should produce for it.
    function automatic scroll_result_t predict_scroll(input touch_item_t rpt);
        scroll_result_t res;
        logic           was_sliding;
        logic           finishing;
        logic           emitting;
        logic [63:0]    step_eff;
        logic [63:0]    fric_eff;
        logic [63:0]    dur;
        logic [63:0]    t_end;
        logic [63:0]    t_from;
        logic [63:0]    t_to;
        logic [63:0]    interval;
        logic [63:0]    num;
        logic [63:0]    den;
        logic [63:0]    span;
        was_sliding = slide_on;
        res         = '0;
        step_eff    = (reg_step == 16'd0) ? 64'd1 : {48'd0, reg_step};
        fric_eff    = (reg_friction == 16'd0) ? 64'd1 : {48'd0, reg_friction};
        if (rpt.op == OP_TOUCH) begin
            if (rpt.holding) begin
                // Held gesture: distances pass through, velocities are latched.
                slide_on         = 1'b0;
                res.scroll_valid = 1'b1;
                res.out_x        = round_sat(rpt.dx[23] ^ reg_natural, mag24(rpt.dx), step_eff);
                res.out_y        = round_sat(rpt.dy[23] ^ reg_natural, mag24(rpt.dy), step_eff);
                held_vx          = rpt.vx;
                held_vy          = rpt.vy;
            end else begin
                // Release: start sliding if either latched speed is high enough.
                if (mag24({{8{held_vx[15]}}, held_vx}) > reg_trigger ||
                    mag24({{8{held_vy[15]}}, held_vy}) > reg_trigger) begin
                    dur              = 64'd1000 * mag24({{8{held_vy[15]}}, held_vy}) / fric_eff;
                    slide_on         = 1'b1;
                    slide_elapsed_ms = 24'd0;
                    slide_vel        = held_vy;
                    slide_len_ms     = (dur > SAT24) ? 24'hFF_FFFF : dur[23:0];
                end else if (rpt.moved) begin
                    slide_on = 1'b0;
                end
                held_vx = 16'd0;
                held_vy = 16'd0;
            end
        end else if (slide_on) begin
            // Tick: emit the distance covered in this interval, or the rest.
            t_end     = {40'd0, slide_len_ms};
            t_from    = {40'd0, slide_elapsed_ms};
            interval  = {54'd0, reg_tick_ms};
            t_to      = 64'd0;
            finishing = 1'b0;
            emitting  = 1'b1;
            if (t_from + interval < t_end) begin
                t_to = t_from + interval;
            end else if (t_from < t_end) begin
                t_to      = t_end;
                finishing = 1'b1;
            end else begin
                finishing = 1'b1;
                emitting  = 1'b0;
            end
            if (emitting) begin
                num = mag24({{8{slide_vel[15]}}, slide_vel}) * (t_to - t_from)
                      * (64'd2 * t_end - t_from - t_to) * 64'd256;
                den = 64'd2000 * t_end * step_eff;
                res.scroll_valid = 1'b1;
                res.out_y        = round_sat(slide_vel[15] ^ reg_natural, num, den);
            end
            span             = t_from + interval;
            slide_elapsed_ms = (span > SAT24) ? 24'hFF_FFFF : span[23:0];
            if (finishing) slide_on = 1'b0;
        end
        res.active  = slide_on;
        res.changed = slide_on ^ was_sliding;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Checks every result transaction against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_scrolls.size() == 0) begin
                report_mismatch("result with nothing pending", 24'd0, 24'd0);
            end else begin
                head_res = expected_scrolls.pop_front();
                if (m_scroll_valid !== head_res.scroll_valid)
                    report_mismatch("scroll_valid", {23'd0, m_scroll_valid},
                                    {23'd0, head_res.scroll_valid});
                if (m_scroll_out_x !== head_res.out_x)
                    report_mismatch("scroll_out_x", m_scroll_out_x, head_res.out_x);
                if (m_scroll_out_y !== head_res.out_y)
                    report_mismatch("scroll_out_y", m_scroll_out_y, head_res.out_y);
                if (m_inertia_active !== head_res.active)
                    report_mismatch("inertia_active", {23'd0, m_inertia_active},
                                    {23'd0, head_res.active});
                if (m_inertia_changed !== head_res.changed)
                    report_mismatch("inertia_changed", {23'd0, m_inertia_changed},
                                    {23'd0, head_res.changed});
            end
        end
    end

    // Result receiver with random stalls and an occasional long hold-off.
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_req > 0) begin
                stall         = sink_hold_req;
                sink_hold_req = 0;
            end else begin
                stall = $urandom_range(0, sink_max_gap);
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Offers one transaction after a random gap and records its prediction.
    task automatic send_item(input logic op, holding, input logic [23:0] dx, dy,
                             input logic [15:0] vx, vy, input logic moved);
        touch_item_t rpt;
        int          gap;
        rpt.op      = op;
        rpt.holding = holding;
        rpt.dx      = dx;
        rpt.dy      = dy;
        rpt.vx      = vx;
        rpt.vy      = vy;
        rpt.moved   = moved;
        gap = $urandom_range(0, src_max_gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_op            <= rpt.op;
        s_holding       <= rpt.holding;
        s_scroll_dx     <= rpt.dx;
        s_scroll_dy     <= rpt.dy;
        s_velocity_x    <= rpt.vx;
        s_velocity_y    <= rpt.vy;
        s_pointer_moved <= rpt.moved;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_scrolls.push_back(predict_scroll(rpt));
        items_sent++;
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_scrolls.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_TRIGGER_SPEED:  reg_trigger  = data[14:0];
            CFG_FRICTION:       reg_friction = data;
            CFG_TICK_INTERVAL:  reg_tick_ms  = data[9:0];
            CFG_STEP_DISTANCE:  reg_step     = data;
            CFG_NATURAL_SCROLL: reg_natural  = data[0];
            default: ;
        endcase
    endtask

    // Reprograms all registers once the block has gone idle.
    task automatic program_regs(input int trig, fric, tick, step, nat);
        wait_for_drain();
        repeat (4) @(negedge aclk);
        write_reg(CFG_TRIGGER_SPEED, trig[15:0]);
        write_reg(CFG_FRICTION, fric[15:0]);
        write_reg(CFG_TICK_INTERVAL, tick[15:0]);
        write_reg(CFG_STEP_DISTANCE, step[15:0]);
        write_reg(CFG_NATURAL_SCROLL, nat[15:0]);
        // A write to an index past the register list must change nothing.
        write_reg(CFG_UNUSED_IDX, 16'($urandom));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [23:0] rand_dist();
        logic [23:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0:       v = 24'h800000;
            1:       v = 24'h7FFFFF;
            2, 3:    v = 24'($urandom_range(0, 8191)) - 24'd4096;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_vel();
        logic [15:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0:       v = 16'h8000;
            1:       v = 16'h7FFF;
            2, 3:    v = 16'($urandom_range(0, 4095)) - 16'd2048;
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_noise();
        send_item($urandom_range(0, 1), $urandom_range(0, 1), rand_dist(), rand_dist(),
                  rand_vel(), rand_vel(), $urandom_range(0, 1));
    endtask

    // One gesture: held reports, a release, then a run of ticks with the odd
    // stray transaction mixed in.
    task automatic run_gesture();
        int holds;
        int ticks;
        holds = $urandom_range(1, 4);
        ticks = $urandom_range(0, 40);
        repeat (holds)
            send_item(OP_TOUCH, 1'b1, rand_dist(), rand_dist(), rand_vel(), rand_vel(),
                      $urandom_range(0, 1));
        send_item(OP_TOUCH, 1'b0, rand_dist(), rand_dist(), rand_vel(), rand_vel(),
                  $urandom_range(0, 1));
        repeat (ticks) begin
            if ($urandom_range(0, 19) == 0)
                send_noise();
            else
                send_item(OP_TICK, $urandom_range(0, 1), rand_dist(), rand_dist(),
                          rand_vel(), rand_vel(), $urandom_range(0, 1));
        end
    endtask

    // Held reports at the field extremes, then sign flip and rounding.
    task automatic test_passthrough();
        send_item(OP_TOUCH, 1'b1, 24'h800000, 24'h7FFFFF, 16'h8000, 16'h7FFF, 1'b1);
        send_item(OP_TOUCH, 1'b1, 24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000, 1'b0);
        send_item(OP_TOUCH, 1'b1, 24'h000000, 24'hFFFFFF, 16'h0000, 16'hFFFF, 1'b0);
        program_regs(100, 1000, 16, 2, 1);
        // Natural scroll turns the most negative distance into a saturated
        // positive one; a distance of 1.5 steps rounds away from zero.
        send_item(OP_TOUCH, 1'b1, 24'h800000, 24'h000003, 16'h0000, 16'h0000, 1'b0);
        send_item(OP_TOUCH, 1'b0, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 1'b0);
    endtask

    // Full slide life cycle, cancellation, zero duration and a speed that
    // only equals the trigger.
    task automatic test_slide_lifecycle();
        program_regs(100, 1000, 400, 1, 0);
        send_item(OP_TOUCH, 1'b1, 24'h000100, 24'h000200, 16'd0, 16'd1200, 1'b0);
        send_item(OP_TOUCH, 1'b0, 24'h000000, 24'h000000, 16'd0, 16'd0, 1'b0);
        repeat (3) send_item(OP_TICK, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TICK, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TOUCH, 1'b1, 24'd0, 24'd0, 16'd0, -16'sd900, 1'b0);
        send_item(OP_TOUCH, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TICK, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TOUCH, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TOUCH, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b1);
        send_item(OP_TOUCH, 1'b1, 24'd0, 24'd0, 16'd500, 16'd0, 1'b0);
        send_item(OP_TOUCH, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TICK, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TOUCH, 1'b1, 24'd0, 24'd0, 16'd0, 16'd100, 1'b0);
        send_item(OP_TOUCH, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TICK, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b0);
    endtask

    // Register extremes: saturated duration, then zero friction, zero step
    // and zero tick interval.
    task automatic test_register_extremes();
        program_regs(32767, 1, 1023, 65535, 1);
        send_item(OP_TOUCH, 1'b1, 24'h123456, 24'hFEDCBA, 16'd0, 16'h8000, 1'b0);
        send_item(OP_TOUCH, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b0);
        send_item(OP_TICK, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b0);
        program_regs(0, 0, 0, 0, 0);
        send_item(OP_TOUCH, 1'b1, 24'h123456, 24'h000180, 16'd0, 16'd1000, 1'b0);
        send_item(OP_TOUCH, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b0);
        repeat (2) send_item(OP_TICK, 1'b0, 24'd0, 24'd0, 16'd0, 16'd0, 1'b0);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // then the sender waits for everything to come back.
    task automatic test_backpressure();
        program_regs(50, 4000, 200, 1, 0);
        src_max_gap   = 0;
        sink_hold_req = 400;
        for (int i = 0; i < 24; i++) begin
            if (i % 6 == 0)
                send_item(OP_TOUCH, 1'b1, rand_dist(), rand_dist(), rand_vel(), rand_vel(),
                          1'b0);
            else if (i % 6 == 1)
                send_item(OP_TOUCH, 1'b0, rand_dist(), rand_dist(), rand_vel(), rand_vel(),
                          1'b0);
            else
                send_noise();
        end
        wait_for_drain();
    endtask

    // Random gestures and noise over a series of register settings.
    task automatic test_random_traffic();
        int target;
        int phase_end;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            case ($urandom_range(0, 4))
                0: program_regs(0, $urandom_range(0, 1), $urandom_range(0, 1),
                                $urandom_range(0, 1), $urandom_range(0, 1));
                1: program_regs(32767, 65535, 1023, 65535, $urandom_range(0, 1));
                default: program_regs($urandom_range(0, 2000), $urandom_range(500, 65535),
                                      $urandom_range(50, 1023), $urandom_range(1, 512),
                                      $urandom_range(0, 1));
            endcase
            case ($urandom_range(0, 2))
                0:       src_max_gap = 0;
                1:       src_max_gap = 3;
                default: src_max_gap = 18;
            endcase
            case ($urandom_range(0, 2))
                0:       sink_max_gap = 0;
                1:       sink_max_gap = 3;
                default: sink_max_gap = 18;
            endcase
            phase_end = items_sent + $urandom_range(100, 250);
            while (items_sent < phase_end && items_sent < target) begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 5)) send_noise();
                else
                    run_gesture();
            end
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_op            = OP_TOUCH;
        s_holding       = 1'b0;
        s_scroll_dx     = '0;
        s_scroll_dy     = '0;
        s_velocity_x    = '0;
        s_velocity_y    = '0;
        s_pointer_moved = 1'b0;
        mismatch_count  = 0;
        cycle_count     = 0;
        items_sent      = 0;
        src_max_gap     = 3;
        sink_max_gap    = 3;
        sink_hold_req   = 0;

        // Predictor starts from the reset state of the block.
        slide_on         = 1'b0;
        held_vx          = '0;
        held_vy          = '0;
        slide_vel        = '0;
        slide_len_ms     = '0;
        slide_elapsed_ms = '0;
        reg_trigger      = 15'd100;
        reg_friction     = 16'd1000;
        reg_tick_ms      = 10'd16;
        reg_step         = 16'd1;
        reg_natural      = 1'b0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_passthrough();
        test_slide_lifecycle();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ise_pkg.sv
sv/ise_mul.sv
sv/ise_div.sv
sv/inertia_scroll_engine_core.sv
sv/ise_checker.sv
test/tb.sv
